// File: sv/e2d_pkg.sv
// Package: shared types and constants of the extended-to-double converter.
package e2d_pkg;

   localparam int unsigned SIG_W  = 64;
   localparam int unsigned EXP_W  = 15;
   localparam int unsigned MANT_W = 53;
   localparam int unsigned LZ_W   = 6;
   localparam int unsigned F_W    = 18;
   localparam int unsigned STEP_W = 16;

   localparam int unsigned EXT_BIAS      = 16383;
   localparam int unsigned EXT_FRAC_BITS = 63;
   localparam int unsigned EXT_OFFSET    = EXT_BIAS + EXT_FRAC_BITS;
   localparam int unsigned ROUND_SHIFT   = SIG_W - MANT_W;

   localparam logic signed [F_W-1:0] F_SUB_MIN  = -18'sd1074;
   localparam logic signed [F_W-1:0] F_OVF_MAX  = 18'sd971;
   localparam logic signed [F_W-1:0] F_EXP_BIAS = 18'sd1075;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_ROUND,
      ST_SCALE,
      ST_HALVE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic zero;
      logic norm;
      logic round;
      logic setup;
      logic finish;
      logic halve;
      logic sub;
   } cmd_type;

   typedef struct packed {
      logic sig_zero;
      logic norm_done;
      logic need_halve;
      logic halve_done;
   } status_type;

endpackage

// File: sv/extended80_to_double.sv
// Top level: x87 80-bit extended value to binary64 bit pattern.
//  channel | ports                                  | dir
//  req     | req_valid req_stall req_significand    | in
//          | req_sign_exponent                      |
//  rsp     | rsp_valid rsp_stall rsp_double_bits    | out
// One word at a time: the next word is not accepted until the result is taken.
// A zero significand goes straight to the result. Otherwise the word is normalized
// by 8-bit or 1-bit shifts, rounded and scaled; subnormals then go through
// stepwise halving before the result is formed.
// Synchronous active-high reset returns the controller to idle.
// req_stall stays high from accept until the result word is taken.
module extended80_to_double (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_significand,
   input  logic [15:0] req_sign_exponent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_double_bits
);

   e2d_pkg::cmd_type    cmd;
   e2d_pkg::status_type status;

   e2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   e2d_dp u_dp (
      .clock             (clock),
      .cmd               (cmd),
      .req_significand   (req_significand),
      .req_sign_exponent (req_sign_exponent),
      .status            (status),
      .rsp_double_bits   (rsp_double_bits)
   );

   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input open while result pending");

   a_no_result_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid) else $error("result too early");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_double_bits)))
      else $error("stalled result changed");

endmodule

// File: sv/e2d_dp.sv
// Datapath: normalize, round to 53 bits, scale and stepwise subnormal halving.
module e2d_dp (
   input  logic                clock,
   input  e2d_pkg::cmd_type    cmd,
   input  logic [63:0]         req_significand,
   input  logic [15:0]         req_sign_exponent,
   output e2d_pkg::status_type status,
   output logic [63:0]         rsp_double_bits
);

   logic [e2d_pkg::SIG_W-1:0]  sig_ff, sig_in;
   logic [e2d_pkg::EXP_W-1:0]  exp_ff, exp_in;
   logic                       neg_ff, neg_in;
   logic [e2d_pkg::LZ_W-1:0]   lz_ff, lz_in;
   logic [e2d_pkg::MANT_W-1:0] q_ff, q_in;
   logic signed [e2d_pkg::F_W-1:0] f_ff, f_in;
   logic [e2d_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic [63:0]                res_ff, res_in;

   logic [e2d_pkg::MANT_W:0]   m_rnd;
   logic                       inc;
   logic [e2d_pkg::MANT_W-1:0] q_half;
   logic [10:0]                exp_field;

   always_comb begin
      inc   = sig_ff[10] & ((|sig_ff[9:0]) | sig_ff[11]);
      m_rnd = {1'b0, sig_ff[63:11]} + {{e2d_pkg::MANT_W{1'b0}}, inc};
      // one halving, ties to even
      q_half = {1'b0, q_ff[e2d_pkg::MANT_W-1:1]};
      if (q_ff[0] & q_half[0]) q_half = q_half + 53'd1;
      exp_field = 11'(f_ff + e2d_pkg::F_EXP_BIAS);
   end

   always_comb begin
      sig_in   = sig_ff;
      exp_in   = exp_ff;
      neg_in   = neg_ff;
      lz_in    = lz_ff;
      q_in     = q_ff;
      f_in     = f_ff;
      steps_in = steps_ff;
      res_in   = res_ff;
      if (cmd.load) begin
         sig_in = req_significand;
         exp_in = req_sign_exponent[14:0];
         neg_in = req_sign_exponent[15];
         lz_in  = '0;
      end
      if (cmd.zero) res_in = (exp_ff == '0) ? 64'd0 : {neg_ff, 63'd0};
      if (cmd.norm) begin
         if (sig_ff[63:56] == 8'd0) begin
            sig_in = {sig_ff[55:0], 8'd0};
            lz_in  = lz_ff + 6'd8;
         end else begin
            sig_in = {sig_ff[62:0], 1'b0};
            lz_in  = lz_ff + 6'd1;
         end
      end
      if (cmd.round) begin
         q_in = m_rnd[e2d_pkg::MANT_W] ? {1'b1, 52'd0} : m_rnd[e2d_pkg::MANT_W-1:0];
         f_in = $signed({3'b000, exp_ff} + 18'(e2d_pkg::ROUND_SHIFT)
                + {17'd0, m_rnd[e2d_pkg::MANT_W]} - {12'd0, lz_ff}
                - 18'(e2d_pkg::EXT_OFFSET));
      end
      if (cmd.setup) steps_in = e2d_pkg::STEP_W'(e2d_pkg::F_SUB_MIN - f_ff);
      if (cmd.finish) begin
         if (f_ff > e2d_pkg::F_OVF_MAX) res_in = {neg_ff, 11'h7FF, 52'd0};
         else                           res_in = {neg_ff, exp_field, q_ff[51:0]};
      end
      if (cmd.halve) begin
         q_in     = q_half;
         steps_in = steps_ff - 16'd1;
      end
      if (cmd.sub) res_in = {neg_ff, 10'd0, q_ff};
   end

   always_ff @(posedge clock) begin
      sig_ff   <= sig_in;
      exp_ff   <= exp_in;
      neg_ff   <= neg_in;
      lz_ff    <= lz_in;
      q_ff     <= q_in;
      f_ff     <= f_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
   end

   assign status.sig_zero   = (sig_ff == '0);
   assign status.norm_done  = sig_ff[63];
   assign status.need_halve = (f_ff < e2d_pkg::F_SUB_MIN);
   assign status.halve_done = (q_ff == '0) || (steps_ff == '0);
   assign rsp_double_bits   = res_ff;

endmodule

// File: sv/e2d_ctrl.sv
// Controller: sequences one conversion through the datapath.
module e2d_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  e2d_pkg::status_type status,
   output e2d_pkg::cmd_type    cmd
);

   e2d_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         e2d_pkg::ST_IDLE:  if (req_valid) state_in = e2d_pkg::ST_NORM;
         e2d_pkg::ST_NORM: begin
            if (status.sig_zero)       state_in = e2d_pkg::ST_DONE;
            else if (status.norm_done) state_in = e2d_pkg::ST_ROUND;
         end
         e2d_pkg::ST_ROUND: state_in = e2d_pkg::ST_SCALE;
         e2d_pkg::ST_SCALE: state_in = status.need_halve ? e2d_pkg::ST_HALVE
                                                         : e2d_pkg::ST_DONE;
         e2d_pkg::ST_HALVE: if (status.halve_done) state_in = e2d_pkg::ST_DONE;
         e2d_pkg::ST_DONE:  if (!rsp_stall) state_in = e2d_pkg::ST_IDLE;
         default:           state_in = e2d_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != e2d_pkg::ST_IDLE);
      rsp_valid = (state_ff == e2d_pkg::ST_DONE);
      unique case (state_ff)
         e2d_pkg::ST_IDLE:  cmd.load = req_valid;
         e2d_pkg::ST_NORM: begin
            cmd.zero = status.sig_zero;
            cmd.norm = !status.sig_zero && !status.norm_done;
         end
         e2d_pkg::ST_ROUND: cmd.round = 1'b1;
         e2d_pkg::ST_SCALE: begin
            cmd.setup  = 1'b1;
            cmd.finish = !status.need_halve;
         end
         e2d_pkg::ST_HALVE: begin
            cmd.halve = !status.halve_done;
            cmd.sub   = status.halve_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= e2d_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// File: tb/tb_extended80_to_double.sv
// Testbench: x87 80-bit extended to binary64 converter, checked against a behavioral predictor.
module tb_extended80_to_double;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_significand = '0;
   logic [15:0] req_sign_exponent = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_double_bits;

   typedef struct packed {
      logic [63:0] sig;
      logic [15:0] se;
   } ext_word_type;

   ext_word_type pending_words[$];
   logic [63:0] expected_doubles[$];
   int          n_errors = 0;
   int          n_checked = 0;
   bit          stim_done = 1'b0;
   bit          calm = 1'b0;

   extended80_to_double uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int msb_pos(logic [63:0] v);
      int p;
      p = 0;
      for (int i = 0; i < 64; i++)
         if (v[i]) p = i;
      return p;
   endfunction

   // m nonzero, below 2^53; value m * 2^f
   function automatic logic [63:0] scale_mag(logic [63:0] m, int f);
      int          tb;
      int          be;
      int          steps;
      logic [63:0] q;
      logic        low;
      tb = msb_pos(m);
      be = tb + f;
      if (f >= -1074) begin
         if (be > 1023) return 64'h7FF0000000000000;
         if (be >= -1022)
            return {1'b0, 11'(be + 1023), 52'((m << (52 - tb)))};
         return m << (f + 1074);
      end
      q = m;
      steps = -1074 - f;
      // one nearest-even rounding per halving
      while (steps > 0 && q != 0) begin
         low = q[0];
         q = q >> 1;
         if (low && q[0]) q = q + 1;
         steps--;
      end
      return q;
   endfunction

   function automatic logic [63:0] convert_ext(logic [63:0] sig, logic [15:0] se);
      int          ex;
      int          p;
      int          s;
      int          e;
      logic [63:0] m;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] mag;
      ex = int'(se[14:0]);
      if (ex == 0 && sig == 0) return 64'd0;
      if (sig == 0) mag = 0;
      else begin
         m = sig;
         e = 0;
         p = msb_pos(sig);
         if (p > 52) begin
            s = p - 52;
            rem = sig & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            m = sig >> s;
            if (rem > half || (rem == half && m[0])) m = m + 1;
            if (m == (64'd1 << 53)) begin
               m = m >> 1;
               s++;
            end
            e = s;
         end
         mag = scale_mag(m, e + ex - int'(e2d_pkg::EXT_OFFSET));
      end
      return se[15] ? (mag | 64'h8000000000000000) : mag;
   endfunction

   task automatic push_word(logic [63:0] sig, logic [15:0] se);
      ext_word_type w;
      w.sig = sig;
      w.se = se;
      pending_words.push_back(w);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (req_valid) expected_doubles.push_back(convert_ext(req_significand,
                                                                   req_sign_exponent));
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
               ext_word_type w;
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_significand <= w.sig;
               req_sign_exponent <= w.se;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_doubles.size() == 0) begin
               $display("%0t unexpected word: expected none, actual %h", $time,
                        rsp_double_bits);
               n_errors++;
            end else begin
               logic [63:0] exp_bits;
               exp_bits = expected_doubles.pop_front();
               n_checked++;
               if (exp_bits !== rsp_double_bits) begin
                  $display("%0t double_bits mismatch: expected %h, actual %h", $time,
                           exp_bits, rsp_double_bits);
                  n_errors++;
               end
            end
         end
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 19);
      end
   end

   initial begin
      logic [63:0] sig;
      logic [15:0] se;
      int          r;
      // directed corners
      push_word(64'd0, 16'h0000);
      push_word(64'd0, 16'h8000);
      push_word(64'd0, 16'h3FFF);
      push_word(64'd0, 16'hC000);
      push_word(64'd0, 16'h7FFF);
      push_word(64'h8000000000000000, 16'h7FFF);
      push_word(64'hC000000000000000, 16'hFFFF);
      push_word(64'h8000000000000000, 16'h3FFF);
      push_word(64'hFFFFFFFFFFFFFFFF, 16'hBFFF);
      push_word(64'h80000000000003FF, 16'h3FFF);
      push_word(64'h8000000000000400, 16'h3FFF);
      push_word(64'h8000000000000C00, 16'h3FFF);
      push_word(64'hFFFFFFFFFFFFF800, 16'h43FE);
      push_word(64'hFFFFFFFFFFFFFFFF, 16'h43FE);
      push_word(64'h8000000000000000, 16'h43FF);
      push_word(64'h8000000000000000, 16'h3C01);
      push_word(64'h8000000000000000, 16'h3C00);
      push_word(64'hC000000000000000, 16'h3BCD);
      push_word(64'h8000000000000000, 16'h3BCC);
      push_word(64'hFFFFFFFFFFFFFFFF, 16'h3BCB);
      push_word(64'h0000000000000001, 16'h0000);
      push_word(64'h0000000000000001, 16'h43FF);
      push_word(64'h3FFFFFFFFFFFFFFF, 16'h3FFF);
      push_word(64'hFFFFFFFFFFFFFFFF, 16'h0001);
      push_word(64'h0000000000000003, 16'hBC00);
      for (int i = 0; i < 1500; i++) begin
         r = $urandom_range(9);
         sig = rand64();
         if ($urandom_range(3) == 0) sig = sig >> $urandom_range(63);
         else sig[63] = 1'b1;
         if ($urandom_range(9) == 0) sig[10:0] = 11'h400 ^ 11'($urandom_range(1) << 11);
         se[15] = 1'($urandom_range(1));
         case (r)
            0, 1, 2: se[14:0] = 15'($urandom_range(32767));
            3, 4: se[14:0] = 15'($urandom_range(16383 + 1100, 16383 - 1100));
            5, 6: se[14:0] = 15'($urandom_range(16383 - 1030, 16383 - 1140));
            7: se[14:0] = 15'($urandom_range(16383 + 1030, 16383 + 1020));
            8: se[14:0] = $urandom_range(1) ? 15'h7FFF : 15'h0000;
            default: se[14:0] = 15'($urandom_range(16383 - 1070, 16383 - 1090));
         endcase
         if ($urandom_range(49) == 0) sig = 64'd0;
         push_word(sig, se);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // burst with no idling on either side
      wait (pending_words.size() < 1200);
      @(posedge clock) calm <= 1'b1;
      wait (pending_words.size() < 1000);
      @(posedge clock) calm <= 1'b0;
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req_valid || expected_doubles.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Converted %0d words: zeros, unnormals, overflow to infinity,", n_checked);
      $display("stepwise subnormal halving and rounding ties, under random stalls.");
      if (n_errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
